>>> rtl/core/b64dx_pkg.sv
// Shared types, constants and the character map for the Base64 descramble block.
package b64dx_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  typedef enum logic [CfgIdxW-1:0] {
    CFG_KEY_ZERO  = 2'd0,
    CFG_KEY_ONE   = 2'd1,
    CFG_KEY_TWO   = 2'd2,
    CFG_DESC_EN   = 2'd3
  } cfg_idx_e;

  // Reset values of the registers
  localparam logic [7:0] KeyZeroRst = 8'd107;
  localparam logic [7:0] KeyOneRst  = 8'd101;
  localparam logic [7:0] KeyTwoRst  = 8'd121;
  localparam logic       DescEnRst  = 1'b1;

  // Special characters and sextet offsets
  localparam logic [7:0] CharPad   = 8'h3D;  // '='
  localparam logic [7:0] CharPlus  = 8'h2B;  // '+'
  localparam logic [7:0] CharSlash = 8'h2F;  // '/'
  localparam logic [7:0] OffUpper  = 8'h41;  // 'A' maps to 0
  localparam logic [7:0] OffLower  = 8'h47;  // 'a' maps to 26
  localparam logic [7:0] AddDigit  = 8'h04;  // '0' maps to 52
  localparam logic [5:0] SextPlus  = 6'd62;
  localparam logic [5:0] SextSlash = 6'd63;

  // Queue depth between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // One classified character as carried through the queue
  typedef struct packed {
    logic [5:0] sextet;   // decoded value, zero when invalid
    logic       is_pad;   // '=' seen
    logic       is_bad;   // not a Base64 character
    logic       last;     // end of message
  } class_t;

  // Queue status towards the front
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Map one character to its class
  function automatic class_t classify(input logic [7:0] ch, input logic last);
    class_t     c;
    logic [7:0] tmp;
    c      = '0;
    tmp    = '0;
    c.last = last;
    case (ch) inside
      ["A":"Z"]: begin
        tmp = ch - OffUpper;
        c.sextet = tmp[5:0];
      end
      ["a":"z"]: begin
        tmp = ch - OffLower;
        c.sextet = tmp[5:0];
      end
      ["0":"9"]: begin
        tmp = ch + AddDigit;
        c.sextet = tmp[5:0];
      end
      CharPlus:  c.sextet = SextPlus;
      CharSlash: c.sextet = SextSlash;
      CharPad:   c.is_pad = 1'b1;
      default:   c.is_bad = 1'b1;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/core/b64dx_front.sv
// Front end: takes input beats, classifies each character and pushes it to the queue.
module b64dx_front (
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            char_code_i,
  input  logic                  end_of_text_i,
  input  b64dx_pkg::q_stat_t    q_stat_i,
  output logic                  push_o,
  output b64dx_pkg::class_t     push_data_o
);

  // Accept whenever the queue has room
  assign in_ready_o  = !q_stat_i.full;
  assign push_o      = in_valid_i && !q_stat_i.full;

  // Character map
  assign push_data_o = b64dx_pkg::classify(char_code_i, end_of_text_i);

endmodule

>>> rtl/core/b64dx_queue.sv
// Short flop queue of classified characters between front and back.
module b64dx_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  b64dx_pkg::class_t   push_data_i,
  input  logic                pop_i,
  output b64dx_pkg::class_t   pop_data_o,
  output b64dx_pkg::q_stat_t  stat_o
);

  b64dx_pkg::class_t                   mem_q [b64dx_pkg::QDepth];
  logic [b64dx_pkg::QPtrW-1:0]         wr_ptr_q, wr_ptr_d;
  logic [b64dx_pkg::QPtrW-1:0]         rd_ptr_q, rd_ptr_d;
  logic [b64dx_pkg::QCntW-1:0]         cnt_q, cnt_d;
  logic                                do_push, do_pop;

  assign stat_o.full  = (cnt_q == b64dx_pkg::QCntW'(b64dx_pkg::QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // Pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == b64dx_pkg::QPtrW'(b64dx_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == b64dx_pkg::QPtrW'(b64dx_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> rtl/core/b64dx_back.sv
// Back end: packs sextets into bytes, applies the key when descrambling is on and holds the output register.
module b64dx_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  b64dx_pkg::cfg_idx_e       cfg_index_i,
  input  logic [7:0]                cfg_data_i,
  input  b64dx_pkg::q_stat_t        q_stat_i,
  input  b64dx_pkg::class_t         item_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [7:0]                out_byte_o,
  output logic                      bad_char_seen_o
);

  logic [7:0] key0_q, key1_q, key2_q;
  logic       desc_en_q;
  logic [1:0] phase_q, phase_d;
  logic [7:0] carry_q, carry_d;
  logic [1:0] pos_q, pos_d;
  logic       stopped_q, stopped_d;
  logic       bad_q, bad_d;
  logic       ovalid_q, ovalid_d;
  logic [7:0] obyte_q, obyte_d;
  logic       obad_q, obad_d;
  logic       emit;
  logic [7:0] raw;
  logic [7:0] key;
  logic [7:0] ext;

  // Pop whenever the output slot is free or being freed
  assign pop_o = !q_stat_i.empty && (!ovalid_q || out_ready_i);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_q    <= b64dx_pkg::KeyZeroRst;
      key1_q    <= b64dx_pkg::KeyOneRst;
      key2_q    <= b64dx_pkg::KeyTwoRst;
      desc_en_q <= b64dx_pkg::DescEnRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        b64dx_pkg::CFG_KEY_ZERO: key0_q    <= cfg_data_i;
        b64dx_pkg::CFG_KEY_ONE:  key1_q    <= cfg_data_i;
        b64dx_pkg::CFG_KEY_TWO:  key2_q    <= cfg_data_i;
        b64dx_pkg::CFG_DESC_EN:  desc_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Key select by byte position
  always_comb begin
    case (pos_q)
      2'd0:    key = key0_q;
      2'd1:    key = key1_q;
      default: key = key2_q;
    endcase
  end

  // Packing step
  always_comb begin
    phase_d   = phase_q;
    carry_d   = carry_q;
    pos_d     = pos_q;
    stopped_d = stopped_q;
    bad_d     = bad_q;
    emit      = 1'b0;
    raw       = carry_q;
    ext       = {2'b00, item_i.sextet};
    if (pop_o && !stopped_q) begin
      if (item_i.is_pad) begin
        emit      = !item_i.last && (pos_q == 2'd2);
        stopped_d = 1'b1;
      end else begin
        bad_d   = bad_q | item_i.is_bad;
        phase_d = phase_q + 1'b1;
        case (phase_q)
          2'd0: begin
            carry_d = {item_i.sextet, 2'b00};
          end
          2'd1: begin
            emit    = 1'b1;
            raw     = carry_q | (ext >> 4);
            carry_d = {item_i.sextet[3:0], 4'b0000};
          end
          2'd2: begin
            emit    = 1'b1;
            raw     = carry_q | (ext >> 2);
            carry_d = {item_i.sextet[1:0], 6'b000000};
          end
          default: begin
            emit    = 1'b1;
            raw     = carry_q | ext;
          end
        endcase
      end
    end
    if (emit) begin
      pos_d = (pos_q == 2'd2) ? 2'd0 : pos_q + 1'b1;
    end
    // End of message clears everything but the registers
    if (pop_o && item_i.last) begin
      phase_d   = '0;
      carry_d   = '0;
      pos_d     = '0;
      stopped_d = 1'b0;
      bad_d     = 1'b0;
    end
  end

  // Output register
  always_comb begin
    ovalid_d = ovalid_q && !out_ready_i;
    obyte_d  = obyte_q;
    obad_d   = obad_q;
    if (emit) begin
      ovalid_d = 1'b1;
      obyte_d  = desc_en_q ? (raw ^ key) : raw;
      obad_d   = bad_q | (item_i.is_bad && !item_i.is_pad);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= '0;
      carry_q   <= '0;
      pos_q     <= '0;
      stopped_q <= 1'b0;
      bad_q     <= 1'b0;
      ovalid_q  <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      carry_q   <= carry_d;
      pos_q     <= pos_d;
      stopped_q <= stopped_d;
      bad_q     <= bad_d;
      ovalid_q  <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    obyte_q <= obyte_d;
    obad_q  <= obad_d;
  end

  assign out_valid_o     = ovalid_q;
  assign out_byte_o      = obyte_q;
  assign bad_char_seen_o = obad_q;

`ifndef SYNTHESIS
  // Byte position only counts 0 to 2
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q != 2'd3)
    else $error("byte position out of range");

  // A last character leaves the message state clear
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && item_i.last) |=> (phase_q == 2'd0 && pos_q == 2'd0 && !stopped_q && !bad_q))
    else $error("message state not cleared after last character");

  // A new output beat only appears after a pop
  a_out_from_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) |-> $past(pop_o))
    else $error("output beat without a popped character");

  // Nothing is emitted once padding has stopped the message
  a_stopped_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |-> !emit)
    else $error("byte emitted after padding");
`endif

endmodule

>>> rtl/core/base64_decode_xor_descramble.sv
// Top level of the Base64 decoder with three-byte XOR descrambler.
//
// Input channel: one Base64 character per beat (char_code_i) with end_of_text_i
// marking the last character of a message; valid/ready handshake.
// Output channel: zero or one decoded byte per character (out_byte_o) with
// bad_char_seen_o set once an invalid character has appeared in the message.
// Configuration: cfg_we_i writes cfg_data_i to the register at cfg_index_i
// (0..2 key bytes, 3 descramble enable); write only while the block is idle.
// An accepted character is stored in the queue; its byte, if any, is held in
// the output register. Throughput: one character per cycle while the receiver
// keeps up, limited by the single packing step in the back end, which takes one
// queue entry per cycle unless the output register is held. A two-entry queue
// parts the classifier from the packer; when the receiver stalls the output
// register holds, the queue fills and in_ready_o drops after at most two more
// characters. Reset clears the message state, empties the queue and the output
// register, and loads the default key 107/101/121 with descrambling on.
module base64_decode_xor_descramble (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_code_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       bad_char_seen_o
);

  b64dx_pkg::q_stat_t q_stat;
  b64dx_pkg::class_t  push_data;
  b64dx_pkg::class_t  pop_data;
  logic               push;
  logic               pop;

  b64dx_front u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .char_code_i   (char_code_i),
    .end_of_text_i (end_of_text_i),
    .q_stat_i      (q_stat),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  b64dx_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (q_stat)
  );

  b64dx_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (b64dx_pkg::cfg_idx_e'(cfg_index_i)),
    .cfg_data_i      (cfg_data_i),
    .q_stat_i        (q_stat),
    .item_i          (pop_data),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_byte_o      (out_byte_o),
    .bad_char_seen_o (bad_char_seen_o)
  );

endmodule

>>> dv/tb.sv
// Testbench for the Base64 decoder with three-byte XOR descrambler.
`timescale 1ns / 1ps

module tb;

  localparam int TimeoutCycles = 300000;
  localparam int HoldCycles    = 150;
  localparam int SettleCycles  = 6;
  localparam int PhaseItems    = 300;
  localparam int NumPhases     = 6;
  localparam int IdlePct  [NumPhases] = '{0, 54, 0, 22, 0, 22};
  localparam int StallPct [NumPhases] = '{0, 0, 54, 22, 0, 22};
  localparam int PressPhase = 4;

  // Decoded byte as seen on the output channel
  typedef struct packed {
    logic [7:0] data;
    logic       bad;
  } dec_byte_t;

  // Directed row: character, last flag, and an optional hand-written result
  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
    logic       fixed;
    logic [7:0] byt;
    logic       bad;
  } row_t;

  localparam int NumRows = 26;
  localparam row_t DirRows [NumRows] = '{
    // all-zero sextets give the bare key bytes
    '{"A", 1'b0, 1'b0, 8'h00, 1'b0},
    '{"A", 1'b0, 1'b1, b64dx_pkg::KeyZeroRst, 1'b0},
    '{"A", 1'b0, 1'b1, b64dx_pkg::KeyOneRst, 1'b0},
    '{"A", 1'b1, 1'b1, b64dx_pkg::KeyTwoRst, 1'b0},
    // all-ones sextets
    '{"/", 1'b0, 1'b0, 8'h00, 1'b0},
    '{"/", 1'b0, 1'b1, 8'hFF ^ b64dx_pkg::KeyZeroRst, 1'b0},
    '{"/", 1'b0, 1'b1, 8'hFF ^ b64dx_pkg::KeyOneRst, 1'b0},
    '{"/", 1'b1, 1'b1, 8'hFF ^ b64dx_pkg::KeyTwoRst, 1'b0},
    // invalid characters decode as zero and raise the error flag
    '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'hFF, 1'b0, 1'b1, b64dx_pkg::KeyZeroRst, 1'b1},
    '{"a", 1'b0, 1'b0, 8'h00, 1'b0},
    '{"z", 1'b1, 1'b0, 8'h00, 1'b0},
    // two bytes then padding: carry flushed at position 2, rest ignored
    '{"+", 1'b0, 1'b0, 8'h00, 1'b0},
    '{"0", 1'b0, 1'b0, 8'h00, 1'b0},
    '{"9", 1'b0, 1'b0, 8'h00, 1'b0},
    '{b64dx_pkg::CharPad, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'h80, 1'b1, 1'b0, 8'h00, 1'b0},
    // lone padding as a whole message
    '{b64dx_pkg::CharPad, 1'b1, 1'b0, 8'h00, 1'b0},
    // padding flagged last at position 2: no flush
    '{"Z", 1'b0, 1'b0, 8'h00, 1'b0},
    '{"U", 1'b0, 1'b0, 8'h00, 1'b0},
    '{"I", 1'b0, 1'b0, 8'h00, 1'b0},
    '{b64dx_pkg::CharPad, 1'b1, 1'b0, 8'h00, 1'b0},
    // padding at position 1: nothing, second pad ignored
    '{"Q", 1'b0, 1'b0, 8'h00, 1'b0},
    '{"Q", 1'b0, 1'b0, 8'h00, 1'b0},
    '{b64dx_pkg::CharPad, 1'b0, 1'b0, 8'h00, 1'b0},
    '{b64dx_pkg::CharPad, 1'b1, 1'b0, 8'h00, 1'b0}
  };

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       cfg_we_i      = 1'b0;
  logic [1:0] cfg_index_i   = '0;
  logic [7:0] cfg_data_i    = '0;
  logic       in_valid_i    = 1'b0;
  logic       in_ready_o;
  logic [7:0] char_code_i   = '0;
  logic       end_of_text_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i   = 1'b0;
  logic [7:0] out_byte_o;
  logic       bad_char_seen_o;

  // Hand-written expectation travelling with the beat
  logic       fix_en   = 1'b0;
  logic [7:0] fix_byte = '0;
  logic       fix_bad  = 1'b0;

  // Predictor copy of registers and message state
  logic [7:0] key_sh [0:2] = '{b64dx_pkg::KeyZeroRst, b64dx_pkg::KeyOneRst,
                               b64dx_pkg::KeyTwoRst};
  logic       descr_on = b64dx_pkg::DescEnRst;
  logic [1:0] sx_phase = '0;
  logic [7:0] carry    = '0;
  logic [1:0] byte_pos = '0;
  logic       halted   = 1'b0;
  logic       bad_msg  = 1'b0;

  dec_byte_t pending_bytes [$];
  int errors         = 0;
  int cycle_cnt      = 0;
  int idle_pct       = 0;
  int stall_pct      = 0;
  int hold_req       = 0;
  int hold_ack       = 0;
  int items_in_phase = 0;

  base64_decode_xor_descramble i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .char_code_i    (char_code_i),
    .end_of_text_i  (end_of_text_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .bad_char_seen_o(bad_char_seen_o)
  );

  always begin
    #6;
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
  end

  // {valid, value} of one character
  function automatic logic [6:0] sextet_of(input logic [7:0] ch);
    if (ch >= "A" && ch <= "Z") return {1'b1, 6'(ch - "A")};
    if (ch >= "a" && ch <= "z") return {1'b1, 6'(ch - "a" + 26)};
    if (ch >= "0" && ch <= "9") return {1'b1, 6'(ch - "0" + 52)};
    if (ch == b64dx_pkg::CharPlus) return {1'b1, b64dx_pkg::SextPlus};
    if (ch == b64dx_pkg::CharSlash) return {1'b1, b64dx_pkg::SextSlash};
    return 7'd0;
  endfunction

  // Encode a sextet for the random messages
  function automatic logic [7:0] b64_char(input logic [5:0] v);
    if (v < 26) return 8'("A" + v);
    if (v < 52) return 8'("a" + v - 26);
    if (v < 62) return 8'("0" + v - 52);
    if (v == b64dx_pkg::SextPlus) return b64dx_pkg::CharPlus;
    return b64dx_pkg::CharSlash;
  endfunction

  // Queue one expected output beat
  task automatic expect_byte(input dec_byte_t b);
    pending_bytes.insert(pending_bytes.size(), b);
  endtask

  // Advance the message state by one character; got marks a byte out
  task automatic decode_step(input logic [7:0] ch, input logic last,
                             output logic got, output dec_byte_t res);
    logic [6:0] sx;
    logic [5:0] d;
    logic [7:0] raw;
    got = 1'b0;
    res = '0;
    raw = '0;
    if (!halted) begin
      if (ch == b64dx_pkg::CharPad) begin
        if (!last && byte_pos == 2'd2) begin
          raw = carry;
          got = 1'b1;
        end
        halted = 1'b1;
      end else begin
        sx = sextet_of(ch);
        d  = sx[5:0];
        if (!sx[6]) bad_msg = 1'b1;
        case (sx_phase)
          2'd0: carry = {d, 2'b00};
          2'd1: begin
            raw   = carry | {6'b0, d[5:4]};
            carry = {d[3:0], 4'b0};
            got   = 1'b1;
          end
          2'd2: begin
            raw   = carry | {4'b0, d[5:2]};
            carry = {d[1:0], 6'b0};
            got   = 1'b1;
          end
          default: begin
            raw = carry | {2'b0, d};
            got = 1'b1;
          end
        endcase
        sx_phase = sx_phase + 2'd1;
      end
      if (got) begin
        res.data = descr_on ? raw ^ key_sh[byte_pos] : raw;
        res.bad  = bad_msg;
        byte_pos = (byte_pos == 2'd2) ? 2'd0 : byte_pos + 2'd1;
      end
    end
    if (last) begin
      sx_phase = '0;
      carry    = '0;
      byte_pos = '0;
      halted   = 1'b0;
      bad_msg  = 1'b0;
    end
  endtask

  // Offer one character, with a random gap ahead of it
  task automatic put_char(input logic [7:0] ch, input logic last, input logic fixed,
                          input logic [7:0] byt, input logic bad);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    char_code_i   <= ch;
    end_of_text_i <= last;
    fix_en        <= fixed;
    fix_byte      <= byt;
    fix_bad       <= bad;
    do @(posedge clk_i); while (!in_ready_o);
    items_in_phase++;
  endtask

  // Random message: mostly well-formed, some noise and broken padding
  task automatic send_msg();
    logic [7:0] msg [$];
    int n, kind;
    n    = $urandom_range(1, 14);
    kind = $urandom_range(0, 9);
    if (kind == 9 && $urandom_range(0, 1) == 1) n = 4 * $urandom_range(0, 3) + 3;
    for (int i = 0; i < n; i++) begin
      if (kind == 7 || (kind == 8 && $urandom_range(0, 99) < 15))
        msg.insert(msg.size(), 8'($urandom_range(0, 255)));
      else
        msg.insert(msg.size(), b64_char(6'($urandom_range(0, 63))));
    end
    if (kind != 7) begin
      if (n % 4 == 2) begin
        msg.insert(msg.size(), b64dx_pkg::CharPad);
        msg.insert(msg.size(), b64dx_pkg::CharPad);
      end else if (n % 4 == 3) begin
        msg.insert(msg.size(), b64dx_pkg::CharPad);
      end
    end
    // trailing junk after the padding
    if (kind == 9) begin
      if (n % 4 < 2) msg.insert(msg.size(), b64dx_pkg::CharPad);
      repeat ($urandom_range(1, 4)) msg.insert(msg.size(), 8'($urandom_range(0, 255)));
    end
    foreach (msg[j]) put_char(msg[j], j == msg.size() - 1, 1'b0, 8'h00, 1'b0);
  endtask

  // Drop valid and wait until the block has gone quiet
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_bytes.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write all four registers, keeping the predictor copy in step
  task automatic load_cfg(input logic [7:0] k0, input logic [7:0] k1,
                          input logic [7:0] k2, input logic en);
    logic [7:0]          vals [4];
    b64dx_pkg::cfg_idx_e idx;
    vals[0] = k0;
    vals[1] = k1;
    vals[2] = k2;
    vals[3] = {7'($urandom_range(0, 127)), en};
    for (int i = 0; i < 4; i++) begin
      idx = b64dx_pkg::cfg_idx_e'(i);
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= vals[i];
      @(posedge clk_i);
      case (idx)
        b64dx_pkg::CFG_KEY_ZERO: key_sh[0] = vals[i];
        b64dx_pkg::CFG_KEY_ONE:  key_sh[1] = vals[i];
        b64dx_pkg::CFG_KEY_TWO:  key_sh[2] = vals[i];
        b64dx_pkg::CFG_DESC_EN:  descr_on  = vals[i][0];
        default: ;
      endcase
    end
    cfg_we_i <= 1'b0;
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_ack) begin
        hold_ack = hold_req;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Predict on accepted input beats, check accepted output beats
  always @(posedge clk_i) begin : mon
    logic      got;
    dec_byte_t res;
    dec_byte_t hand;
    dec_byte_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        decode_step(char_code_i, end_of_text_i, got, res);
        if (fix_en) begin
          hand.data = fix_byte;
          hand.bad  = fix_bad;
          expect_byte(hand);
        end else if (got) begin
          expect_byte(res);
        end
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_bytes.size() == 0) begin
          $display("%0t: expected no beat, got byte %02h bad %0b", $time, out_byte_o,
                   bad_char_seen_o);
          errors++;
        end else begin
          want = pending_bytes.pop_front();
          if (out_byte_o !== want.data) begin
            $display("%0t: out_byte expected %02h got %02h", $time, want.data, out_byte_o);
            errors++;
          end
          if (bad_char_seen_o !== want.bad) begin
            $display("%0t: bad_char_seen expected %0b got %0b", $time, want.bad,
                     bad_char_seen_o);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == TimeoutCycles) begin
      $display("%0t: timeout, %0d bytes still expected", $time, pending_bytes.size());
      $display("FAIL base64_decode_xor_descramble");
      $finish;
    end
  end

  // Main sequence
  initial begin
    bit paused;
    paused = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part on reset register values
    foreach (DirRows[r]) begin
      put_char(DirRows[r].ch, DirRows[r].eot, DirRows[r].fixed, DirRows[r].byt,
               DirRows[r].bad);
    end
    wait_idle();

    // random phases, one register setting and idling pattern each
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: load_cfg(8'h00, 8'h00, 8'h00, 1'b1);
        1: load_cfg(8'hFF, 8'hFF, 8'hFF, 1'b1);
        2: load_cfg(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
        5: load_cfg(8'hFF, 8'h00, 8'($urandom), 1'($urandom));
        default: load_cfg(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
      endcase
      idle_pct       = IdlePct[p];
      stall_pct      = StallPct[p];
      items_in_phase = 0;
      while (items_in_phase < PhaseItems) begin
        send_msg();
        if (p == PressPhase && items_in_phase >= 60 && hold_req == hold_ack && !paused &&
            hold_req == 0) begin
          hold_req++;
        end
        // sender pause until the output side has caught up
        if (p == PressPhase && items_in_phase >= 200 && !paused) begin
          paused = 1'b1;
          in_valid_i <= 1'b0;
          do @(posedge clk_i); while (pending_bytes.size() != 0);
        end
      end
      wait_idle();
    end

    if (errors == 0) $display("PASS base64_decode_xor_descramble");
    else $display("FAIL base64_decode_xor_descramble");
    $finish;
  end

endmodule

>>> base64_decode_xor_descramble.f
rtl/core/b64dx_pkg.sv
rtl/core/b64dx_front.sv
rtl/core/b64dx_queue.sv
rtl/core/b64dx_back.sv
rtl/core/base64_decode_xor_descramble.sv
dv/tb.sv
